@@ rtl/core/pwlcm_pkg.sv @@
`timescale 1ns / 1ps

package pwlcm_pkg;

  // Breakpoint ROM size and the number of entries the curve map uses.
  localparam int unsigned RomPoints   = 41;
  localparam int unsigned TablePoints = 41;
  localparam int unsigned PointsUsed  = (TablePoints > RomPoints) ? RomPoints :
                                        ((TablePoints < 1) ? 1 : TablePoints);

  // ROM index width and search counter width (the counter also holds PointsUsed).
  localparam int unsigned IdxW = $clog2(RomPoints);
  localparam int unsigned CntW = $clog2(PointsUsed + 1);

  // Sample and curve value widths.
  localparam int unsigned DataW = 16;

  // One quotient bit per divider step.
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // Depth of the queue between the search front and the arithmetic back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [DataW-1:0] BpRom [RomPoints] = '{
    16'd0,     16'd1540,  16'd3080,  16'd4620,  16'd6160,  16'd7668,  16'd9241,
    16'd10748, 16'd12321, 16'd13828, 16'd15401, 16'd16908, 16'd18481, 16'd19988,
    16'd21561, 16'd23069, 16'd24642, 16'd26149, 16'd27722, 16'd29229, 16'd30802,
    16'd32309, 16'd33882, 16'd35389, 16'd36962, 16'd38470, 16'd40042, 16'd41550,
    16'd43123, 16'd44630, 16'd46203, 16'd47710, 16'd49283, 16'd50790, 16'd52363,
    16'd53871, 16'd55443, 16'd56951, 16'd58524, 16'd60031, 16'd61604
  };

  localparam logic [DataW-1:0] CurveA [RomPoints] = '{
    16'd0,     16'd541,   16'd1081,  16'd1626,  16'd2167,  16'd2712,  16'd3256,
    16'd3801,  16'd4342,  16'd4915,  16'd5448,  16'd5980,  16'd6554,  16'd7127,
    16'd7660,  16'd8233,  16'd8806,  16'd9380,  16'd9912,  16'd10527, 16'd11100,
    16'd11674, 16'd12247, 16'd12861, 16'd13435, 16'd14049, 16'd14664, 16'd15278,
    16'd15933, 16'd16589, 16'd17244, 16'd17900, 16'd18555, 16'd19210, 16'd19907,
    16'd20644, 16'd21340, 16'd22077, 16'd22815, 16'd23593, 16'd24412
  };

  localparam logic [DataW-1:0] CurveB [RomPoints] = '{
    16'd0,     16'd1163,  16'd2331,  16'd3494,  16'd4669,  16'd5816,  16'd7004,
    16'd8151,  16'd9339,  16'd10527, 16'd11674, 16'd12861, 16'd14049, 16'd15237,
    16'd16384, 16'd17572, 16'd18760, 16'd19948, 16'd21217, 16'd22487, 16'd23716,
    16'd24945, 16'd26173, 16'd27443, 16'd28672, 16'd29942, 16'd31212, 16'd32481,
    16'd33792, 16'd35103, 16'd36454, 16'd37806, 16'd39158, 16'd40509, 16'd41779,
    16'd43418, 16'd44646, 16'd46285, 16'd47514, 16'd49152, 16'd50790
  };

  localparam logic [IdxW-1:0] LastIdx = IdxW'(PointsUsed - 1);

  // Curve selection codes.
  typedef enum logic {
    CURVE_A = 1'b0,
    CURVE_B = 1'b1
  } curve_sel_e;

  // Front (search) states.
  typedef enum logic [1:0] {
    F_IDLE,
    F_SEARCH,
    F_PUSH
  } front_state_e;

  // Back (arithmetic) states.
  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_PREP,
    B_DIV,
    B_DONE
  } back_state_e;

  // One interpolation job handed from the front to the back.
  typedef struct packed {
    logic [DataW-1:0] x_off;
    logic [DataW-1:0] den;
    logic [DataW-1:0] y0;
    logic [DataW-1:0] dy;
    logic             clipped;
  } job_t;

  // Breakpoint lookup; entries past the ROM read as zero.
  function automatic logic [DataW-1:0] bp_at(input logic [IdxW-1:0] idx);
    logic [DataW-1:0] val;
    val = '0;
    if (32'(idx) < RomPoints) begin
      val = BpRom[idx];
    end
    return val;
  endfunction

  // Output curve lookup for the selected curve.
  function automatic logic [DataW-1:0] cv_at(input curve_sel_e sel,
                                             input logic [IdxW-1:0] idx);
    logic [DataW-1:0] val;
    val = '0;
    if (32'(idx) < RomPoints) begin
      val = (sel == CURVE_B) ? CurveB[idx] : CurveA[idx];
    end
    return val;
  endfunction

endpackage

@@ rtl/core/piecewise_linear_curve_map.sv @@
`timescale 1ns / 1ps
// Piecewise-linear curve map: maps an unsigned Q0.16 sample through a 41-point
// breakpoint curve to an unsigned Q4.12 value, with rounding to nearest.
// Input channel: drive sample_in_i and raise push; the request is taken on a
// clock edge where push is high and full is low.
// Result channel: while empty is low, mapped_value_o and clipped_o hold the
// oldest result; raise pop to take it. Samples at or past the last breakpoint
// give the last curve value with clipped_o set.
// Configuration: cfg_curve_select_i is written when cfg_valid_i is high; the
// port is always ready. Write it only while no request is in flight.
// Flow: the front scans the breakpoint ROM one entry per cycle, then pushes
// the segment to the queue once the queue has room. The back handles each
// request in turn: load, multiply, rounding, 16 divider steps and the result
// register, which waits until the previous result is popped. The front takes a
// new request only after it has pushed the previous one, while the back may
// still work on earlier ones; the back limits throughput for short scans and
// the scan limits it for long ones.
// A two-entry queue sits between front and back, and the result register holds
// one result while pop is held low; full stays high while the front scans or
// waits for room in the queue.
// Reset clears the curve selection to the first curve and empties the block.
module piecewise_linear_curve_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] sample_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] mapped_value_o,
  output logic        clipped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_curve_select_i
);
  import pwlcm_pkg::*;

  curve_sel_e curve_q;
  logic       job_push;
  logic       job_full;
  job_t       job_in;
  logic       job_pop;
  logic       job_empty;
  job_t       job_out;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q <= CURVE_A;
    end else if (cfg_valid_i) begin
      curve_q <= curve_sel_e'(cfg_curve_select_i);
    end
  end

  // Breakpoint search.
  pwlcm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .sample_i   (sample_in_i),
    .curve_i    (curve_q),
    .job_push_o (job_push),
    .job_full_i (job_full),
    .job_o      (job_in)
  );

  // Job queue between search and arithmetic.
  pwlcm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .full_o  (job_full),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  // Interpolation arithmetic and result register.
  pwlcm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_empty_i    (job_empty),
    .job_pop_o      (job_pop),
    .job_i          (job_out),
    .empty_o        (empty),
    .pop_i          (pop),
    .mapped_value_o (mapped_value_o),
    .clipped_o      (clipped_o)
  );

  // A clamped result carries the last value of the selected curve.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && clipped_o) |->
      (mapped_value_o == cv_at(curve_q, LastIdx)))
    else $error("clamped result differs from the last curve value");

  // No result ever passes the end of the selected curve.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (mapped_value_o <= cv_at(curve_q, LastIdx)))
    else $error("result beyond the end of the curve");

  // An accepted request keeps the front busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("front took a request without going busy");

endmodule

@@ rtl/core/pwlcm_front.sv @@
`timescale 1ns / 1ps

module pwlcm_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [15:0]              sample_i,
  input  pwlcm_pkg::curve_sel_e    curve_i,
  output logic                     job_push_o,
  input  logic                     job_full_i,
  output pwlcm_pkg::job_t          job_o
);
  import pwlcm_pkg::*;

  front_state_e     state_q, state_d;
  logic [DataW-1:0] sample_q;
  logic [CntW-1:0]  idx_q;

  logic             accept;
  logic             step;
  logic             hit;
  logic             clip;
  logic [IdxW-1:0]  cur_idx;
  logic [IdxW-1:0]  prev_idx;
  logic [DataW-1:0] x0;
  logic [DataW-1:0] y0;

  // One breakpoint compare per cycle while searching.
  assign cur_idx  = IdxW'(idx_q);
  assign prev_idx = cur_idx - IdxW'(1);
  assign hit      = (idx_q < CntW'(PointsUsed)) && (sample_q >= bp_at(cur_idx));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (push_i) state_d = F_SEARCH;
      end
      F_SEARCH: begin
        if (!hit) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!job_full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    full_o     = 1'b1;
    accept     = 1'b0;
    step       = 1'b0;
    job_push_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        full_o = 1'b0;
        accept = push_i;
      end
      F_SEARCH: begin
        step = hit;
      end
      F_PUSH: begin
        job_push_o = !job_full_i;
      end
      default: ;
    endcase
  end

  // Build the job from the found segment; clamp at or past the last breakpoint.
  always_comb begin
    clip = (idx_q >= CntW'(PointsUsed)) || (idx_q == '0);
    x0   = bp_at(prev_idx);
    y0   = cv_at(curve_i, prev_idx);
    if (clip) begin
      job_o.x_off   = '0;
      job_o.den     = DataW'(1);
      job_o.y0      = cv_at(curve_i, LastIdx);
      job_o.dy      = '0;
      job_o.clipped = 1'b1;
    end else begin
      job_o.x_off   = sample_q - x0;
      job_o.den     = bp_at(cur_idx) - x0;
      job_o.y0      = y0;
      job_o.dy      = cv_at(curve_i, cur_idx) - y0;
      job_o.clipped = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        idx_q <= '0;
      end else if (step) begin
        idx_q <= idx_q + CntW'(1);
      end
    end
  end

  // Sample register.
  always_ff @(posedge clk_i) begin
    if (accept) sample_q <= sample_i;
  end

endmodule

@@ rtl/core/pwlcm_queue.sv @@
`timescale 1ns / 1ps

module pwlcm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  pwlcm_pkg::job_t data_i,
  input  logic            pop_i,
  output logic            empty_o,
  output pwlcm_pkg::job_t data_o
);
  import pwlcm_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

@@ rtl/core/pwlcm_back.sv @@
`timescale 1ns / 1ps

module pwlcm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_empty_i,
  output logic            job_pop_o,
  input  pwlcm_pkg::job_t job_i,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [15:0]     mapped_value_o,
  output logic            clipped_o
);
  import pwlcm_pkg::*;

  back_state_e        state_q, state_d;
  job_t               job_q;
  logic [2*DataW-1:0] prod_q;
  logic [DataW:0]     rem_q;
  logic [DataW-1:0]   quo_q;
  logic [StepW-1:0]   step_q;
  logic               out_valid_q;
  logic [DataW-1:0]   out_value_q;
  logic               out_clip_q;

  logic               out_free;
  logic               load;
  logic               do_mul;
  logic               do_prep;
  logic               do_div;
  logic               do_out;
  logic               last_step;
  logic [2*DataW:0]   sum;
  logic [DataW:0]     rem_sh;
  logic               ge;

  assign out_free  = !out_valid_q || pop_i;
  assign last_step = (step_q == StepW'(DivSteps - 1));

  // Add half the divisor for round-to-nearest, then one quotient bit per cycle.
  assign sum    = {1'b0, prod_q} + (2*DataW+1)'(job_q.den >> 1);
  assign rem_sh = {rem_q[DataW-1:0], quo_q[DataW-1]};
  assign ge     = (rem_sh >= {1'b0, job_q.den});

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!job_empty_i) state_d = B_MUL;
      end
      B_MUL:  state_d = B_PREP;
      B_PREP: state_d = B_DIV;
      B_DIV: begin
        if (last_step) state_d = B_DONE;
      end
      B_DONE: begin
        if (out_free) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    load    = 1'b0;
    do_mul  = 1'b0;
    do_prep = 1'b0;
    do_div  = 1'b0;
    do_out  = 1'b0;
    unique case (state_q)
      B_IDLE: load    = !job_empty_i;
      B_MUL:  do_mul  = 1'b1;
      B_PREP: do_prep = 1'b1;
      B_DIV:  do_div  = 1'b1;
      B_DONE: do_out  = out_free;
      default: ;
    endcase
  end

  assign job_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_prep) begin
        step_q <= '0;
      end else if (do_div) begin
        step_q <= step_q + StepW'(1);
      end
      if (do_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: multiply, round, restoring divide, then the output register.
  always_ff @(posedge clk_i) begin
    if (load)   job_q  <= job_i;
    if (do_mul) prod_q <= (2*DataW)'(job_q.x_off) * (2*DataW)'(job_q.dy);
    if (do_prep) begin
      rem_q <= sum[2*DataW:DataW];
      quo_q <= sum[DataW-1:0];
    end else if (do_div) begin
      rem_q <= ge ? (rem_sh - {1'b0, job_q.den}) : rem_sh;
      quo_q <= {quo_q[DataW-2:0], ge};
    end
    if (do_out) begin
      out_value_q <= job_q.y0 + quo_q;
      out_clip_q  <= job_q.clipped;
    end
  end

  assign empty_o        = !out_valid_q;
  assign mapped_value_o = out_value_q;
  assign clipped_o      = out_clip_q;

endmodule
